// ===== rtl/t4bws_pkg.sv =====
// ----------------------------------------------------------------------------
// t4bws_pkg: shared types and constants for the bone weight slot store
// Holds the store geometry, the beat payload structs, the command and outcome
// codes, the controller states and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package t4bws_pkg;

	// Store geometry.
	localparam int VERTEX_DEPTH     = 4096;
	localparam int SLOTS_PER_VERTEX = 4;
	localparam int SHOWN_SLOTS      = 4;

	// Field widths fixed by the interface.
	localparam int WORD_W = 16;
	localparam int VIDX_W = 12;
	localparam int CFG_W  = 13;
	localparam int FRAC_W = 16;

	// Derived widths.
	localparam int ADDR_W     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int CNT_W      = $clog2(VERTEX_DEPTH + 1);
	localparam int SLOT_IDX_W = $clog2(SLOTS_PER_VERTEX);
	localparam int TOTAL_W    = WORD_W + $clog2(SLOTS_PER_VERTEX);
	localparam int NUM_W      = WORD_W + FRAC_W + 1;
	localparam int QUO_W      = FRAC_W + 1;
	localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
	localparam int ROW_W      = 2 * WORD_W * SLOTS_PER_VERTEX;

	// Configuration port.
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = PADDR_W'(0);

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_NORM  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OUT_FREE      = 2'd0,
		OUT_REPLACED  = 2'd1,
		OUT_DISCARDED = 2'd2,
		OUT_DONE      = 2'd3
	} outcome_t;

	typedef struct packed {
		kind_t              kind;
		logic [VIDX_W-1:0]  vertex_index;
		logic [WORD_W-1:0]  bone_index;
		logic [WORD_W-1:0]  weight;
	} cmd_item_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [WORD_W-1:0]  bone_slot_a;
		logic [WORD_W-1:0]  bone_slot_b;
		logic [WORD_W-1:0]  bone_slot_c;
		logic [WORD_W-1:0]  bone_slot_d;
		logic [WORD_W-1:0]  weight_slot_a;
		logic [WORD_W-1:0]  weight_slot_b;
		logic [WORD_W-1:0]  weight_slot_c;
		logic [WORD_W-1:0]  weight_slot_d;
		logic               overflow_seen;
	} rsp_item_t;

	// One memory row holds every slot of one vertex.
	typedef struct packed {
		logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] bones;
		logic [SLOTS_PER_VERTEX-1:0][WORD_W-1:0] weights;
	} row_t;

	// Result of an add applied to one row.
	typedef struct packed {
		logic     write;
		logic     set_overflow;
		outcome_t outcome;
		row_t     row;
	} update_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_NRD,
		ST_NSUM,
		ST_NCHK,
		ST_NDIV,
		ST_NWR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/t4bws_row_ram.sv =====
// ----------------------------------------------------------------------------
// t4bws_row_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and updates only
// when a read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module t4bws_row_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/t4bws_divider.sv =====
// ----------------------------------------------------------------------------
// t4bws_divider: iterative restoring divider for weight normalization
// Produces one quotient bit per cycle. The numerator is known to be below
// the divisor times two to the quotient width, so the quotient never spills.
// ----------------------------------------------------------------------------
`default_nettype none

module t4bws_divider import t4bws_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   numer,
	input  wire logic [TOTAL_W-1:0] denom,
	output logic                    busy,
	output logic      [QUO_W-1:0]   quotient
);

	logic [TOTAL_W-1:0]   rem_q;
	logic [TOTAL_W-1:0]   den_q;
	logic [QUO_W-1:0]     shift_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TOTAL_W:0]     trial;
	logic [TOTAL_W:0]     diff;
	logic                 fits;

	assign trial = {rem_q, shift_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// The low numerator bits shift out at the top while quotient bits enter
	// at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= TOTAL_W'(numer[NUM_W-1:QUO_W]);
			shift_q <= numer[QUO_W-1:0];
			den_q   <= denom;
		end else if (cnt_q != '0) begin
			rem_q   <= fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
			shift_q <= {shift_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = shift_q;

endmodule

`default_nettype wire

// ===== rtl/t4bws_slot_update.sv =====
// ----------------------------------------------------------------------------
// t4bws_slot_update: slot selection for an add
// Finds the first empty slot of a row, or else the first smallest slot, and
// forms the row to write back with its outcome code.
// ----------------------------------------------------------------------------
`default_nettype none

module t4bws_slot_update import t4bws_pkg::*; (
	input  wire row_t              row_in,
	input  wire logic [WORD_W-1:0] bone,
	input  wire logic [WORD_W-1:0] weight,
	input  wire logic              in_range,
	output update_t                upd
);

	logic                  free_found;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic [SLOT_IDX_W-1:0] low_idx;
	logic [WORD_W-1:0]     low_w;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
			if (!free_found && row_in.weights[s] == '0) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(s);
			end
		end

		// Strict compare keeps the lowest-numbered slot on ties.
		low_idx = '0;
		low_w   = row_in.weights[0];
		for (int s = 1; s < SLOTS_PER_VERTEX; s++) begin
			if (row_in.weights[s] < low_w) begin
				low_idx = SLOT_IDX_W'(s);
				low_w   = row_in.weights[s];
			end
		end

		upd              = '0;
		upd.row          = row_in;
		upd.outcome      = OUT_DISCARDED;
		if (in_range) begin
			if (free_found) begin
				upd.row.bones[free_idx]   = bone;
				upd.row.weights[free_idx] = weight;
				upd.write                 = 1'b1;
				upd.outcome               = OUT_FREE;
			end else begin
				upd.set_overflow = 1'b1;
				if (low_w < weight) begin
					upd.row.bones[low_idx]   = bone;
					upd.row.weights[low_idx] = weight;
					upd.write                = 1'b1;
					upd.outcome              = OUT_REPLACED;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/top4_bone_weight_slots.sv =====
// ----------------------------------------------------------------------------
// top4_bone_weight_slots: per-vertex store of four (bone, weight) slots
// Command channel in, one response beat per command out, APB register for
// the number of vertices walked by the normalize pass.
// ----------------------------------------------------------------------------
// Each vertex owns one row of a single-port-read, single-port-write RAM that
// holds all of its bone identifiers and Q0.16 weights, so an add is one row
// read followed by one row write-back and a read is one row read. A command
// is accepted and its read issued, then an add modifies and writes back the
// row, and the response register is loaded once it is free. A normalize
// with the overflow flag set walks vertex_count rows (limited to the store
// depth): each row is read and its total registered and checked; a nonzero
// total runs the one-bit-per-cycle dividers (one per slot, 17 quotient bits)
// and writes the row back, while a zero total leaves it; without the flag
// it answers without a walk. A clear writes zero to every row. After reset
// the same clearing pass runs, during which no command is accepted;
// configuration writes are taken at all times. Commands are processed one
// at a time, and the next command may be accepted while a response beat
// still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module top4_bone_weight_slots import t4bws_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Command channel.
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire cmd_item_t          cmd,
	// Response channel.
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_item_t               rsp,
	// APB configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// Controller state and the command being worked on.
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   vcnt_q, vcnt_d;
	logic               flag_q, flag_d;
	logic [CFG_W-1:0]   vertex_count_q;
	kind_t              kind_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               in_range_q;
	logic [WORD_W-1:0]  bone_q;
	logic [WORD_W-1:0]  weight_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_sum;

	// Response register.
	rsp_item_t          rsp_q, rsp_d;
	logic               rsp_valid_q;
	logic               rsp_load;
	logic               rsp_free;

	// Memory port.
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	row_t               mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	row_t               mem_rdata;

	// Helpers.
	logic               capture;
	logic               total_load;
	logic               div_start;
	logic [ADDR_W-1:0]  cmd_addr;
	logic               cmd_in_range;
	logic [CNT_W-1:0]   limit;
	logic               sweep_last;
	logic               norm_last;
	update_t            upd;
	row_t               show_row;
	logic               show_en;
	row_t               norm_row;

	logic [SLOTS_PER_VERTEX-1:0]             div_busy;
	logic [SLOTS_PER_VERTEX-1:0][QUO_W-1:0]  div_quo;
	logic [SLOTS_PER_VERTEX-1:0][NUM_W-1:0]  div_numer;

	logic [SHOWN_SLOTS-1:0][WORD_W-1:0] shown_bones;
	logic [SHOWN_SLOTS-1:0][WORD_W-1:0] shown_weights;

	// ------------------------------------------------------------------
	// Configuration register. pready is tied high, so every access
	// completes in its access phase. Unknown addresses read as zero and
	// ignore writes.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_VERTEX_COUNT) ? PDATA_W'(vertex_count_q) : '0;

	// The normalize pass never walks past the end of the store.
	assign limit = (32'(vertex_count_q) < 32'(VERTEX_DEPTH)) ?
		CNT_W'(vertex_count_q) : CNT_W'(VERTEX_DEPTH);

	// ------------------------------------------------------------------
	// Row memory and the add datapath.
	// ------------------------------------------------------------------
	t4bws_row_ram #(
		.DEPTH (VERTEX_DEPTH),
		.WIDTH (ROW_W),
		.AW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	t4bws_slot_update u_update (
		.row_in   (mem_rdata),
		.bone     (bone_q),
		.weight   (weight_q),
		.in_range (in_range_q),
		.upd      (upd)
	);

	assign cmd_addr     = ADDR_W'(cmd.vertex_index);
	assign cmd_in_range = (32'(cmd.vertex_index) < 32'(VERTEX_DEPTH));

	// ------------------------------------------------------------------
	// Normalize datapath: the row total is registered, then every slot
	// gets its own divider computing round(w * 2^16 / total).
	// ------------------------------------------------------------------
	always_comb begin
		total_sum = '0;
		for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
			total_sum = total_sum + TOTAL_W'(mem_rdata.weights[s]);
		end
	end

	for (genvar g = 0; g < SLOTS_PER_VERTEX; g++) begin : g_div
		assign div_numer[g] = NUM_W'({mem_rdata.weights[g], FRAC_W'(0)})
			+ NUM_W'(total_q >> 1);

		t4bws_divider u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.numer    (div_numer[g]),
			.denom    (total_q),
			.busy     (div_busy[g]),
			.quotient (div_quo[g])
		);
	end

	// A quotient of exactly 1.0 saturates to the largest Q0.16 value.
	always_comb begin
		norm_row       = mem_rdata;
		for (int s = 0; s < SLOTS_PER_VERTEX; s++) begin
			norm_row.weights[s] = div_quo[s][QUO_W-1] ? '1 : div_quo[s][WORD_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Response formatting: slots beyond the fourth are not shown, and a
	// vertex outside the store shows all zero.
	// ------------------------------------------------------------------
	always_comb begin
		for (int s = 0; s < SHOWN_SLOTS; s++) begin
			shown_bones[s]   = '0;
			shown_weights[s] = '0;
			if (show_en && s < SLOTS_PER_VERTEX) begin
				shown_bones[s]   = show_row.bones[SLOT_IDX_W'(s)];
				shown_weights[s] = show_row.weights[SLOT_IDX_W'(s)];
			end
		end
	end

	assign show_row = (kind_q == KIND_ADD) ? upd.row : mem_rdata;
	assign show_en  = (state_q == ST_EXEC) && in_range_q;

	assign sweep_last = (vcnt_q == CNT_W'(VERTEX_DEPTH - 1));
	assign norm_last  = ((vcnt_q + CNT_W'(1)) == limit);
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	// ------------------------------------------------------------------
	// Controller.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			vcnt_q      <= '0;
			flag_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vcnt_q  <= vcnt_d;
			flag_q  <= flag_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			kind_q     <= cmd.kind;
			addr_q     <= cmd_addr;
			in_range_q <= cmd_in_range;
			bone_q     <= cmd.bone_index;
			weight_q   <= cmd.weight;
		end
		if (total_load) begin
			total_q <= total_sum;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		vcnt_d     = vcnt_q;
		flag_d     = flag_q;
		cmd_ready  = 1'b0;
		capture    = 1'b0;
		total_load = 1'b0;
		div_start  = 1'b0;
		rsp_load   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = vcnt_q[ADDR_W-1:0];
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = vcnt_q[ADDR_W-1:0];

		unique case (state_q)
			ST_INIT: begin
				// Clearing pass after reset.
				mem_we = 1'b1;
				if (sweep_last) begin
					vcnt_d  = '0;
					state_d = ST_IDLE;
				end else begin
					vcnt_d = vcnt_q + CNT_W'(1);
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					capture   = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = cmd_addr;
					unique case (cmd.kind) inside
						KIND_ADD, KIND_READ: begin
							state_d = ST_EXEC;
						end
						KIND_NORM: begin
							vcnt_d = '0;
							if (flag_q && limit != '0) begin
								state_d = ST_NRD;
							end else begin
								state_d = ST_DONE;
							end
						end
						KIND_CLEAR: begin
							flag_d  = 1'b0;
							vcnt_d  = '0;
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_EXEC: begin
				// The read data stays put while the response register is
				// full, so the write-back simply waits.
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
					if (kind_q == KIND_ADD) begin
						mem_we    = upd.write;
						mem_waddr = addr_q;
						mem_wdata = upd.row;
						flag_d    = flag_q | upd.set_overflow;
					end
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last) begin
					vcnt_d  = '0;
					state_d = ST_DONE;
				end else begin
					vcnt_d = vcnt_q + CNT_W'(1);
				end
			end
			ST_NRD: begin
				mem_re  = 1'b1;
				state_d = ST_NSUM;
			end
			ST_NSUM: begin
				total_load = 1'b1;
				state_d    = ST_NCHK;
			end
			ST_NCHK: begin
				// A vertex with a zero total keeps its weights.
				if (total_q == '0) begin
					if (norm_last) begin
						state_d = ST_DONE;
					end else begin
						vcnt_d  = vcnt_q + CNT_W'(1);
						state_d = ST_NRD;
					end
				end else begin
					div_start = 1'b1;
					state_d   = ST_NDIV;
				end
			end
			ST_NDIV: begin
				if (div_busy == '0) begin
					state_d = ST_NWR;
				end
			end
			ST_NWR: begin
				mem_we    = 1'b1;
				mem_wdata = norm_row;
				if (norm_last) begin
					state_d = ST_DONE;
				end else begin
					vcnt_d  = vcnt_q + CNT_W'(1);
					state_d = ST_NRD;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Response beat contents. Normalize and clear show zero slots; the
	// overflow bit is the flag as it stands after the command.
	always_comb begin
		rsp_d               = '0;
		rsp_d.outcome       = OUT_DONE;
		if (state_q == ST_EXEC && kind_q == KIND_ADD) begin
			rsp_d.outcome = upd.outcome;
		end
		rsp_d.bone_slot_a   = shown_bones[0];
		rsp_d.bone_slot_b   = shown_bones[1];
		rsp_d.bone_slot_c   = shown_bones[2];
		rsp_d.bone_slot_d   = shown_bones[3];
		rsp_d.weight_slot_a = shown_weights[0];
		rsp_d.weight_slot_b = shown_weights[1];
		rsp_d.weight_slot_c = shown_weights[2];
		rsp_d.weight_slot_d = shown_weights[3];
		rsp_d.overflow_seen = flag_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== sim/top4_bone_weight_slots_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top4_bone_weight_slots_test: self-checking bench for the bone weight slot store
// Drives add, read, normalize and clear commands over the command channel,
// programs the vertex count over the register port between phases, predicts
// every response beat from a private copy of the slot store and compares the
// beats field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module top4_bone_weight_slots_test;
	import t4bws_pkg::*;

	// A normalize over the whole store with every vertex populated is the
	// longest stretch with no beat moving, longer than the reset clearing pass
	// or a clear. The watchdog allows several times the worst of these.
	localparam int STALL_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASES       = 8;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	cmd_item_t          cmd       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_item_t          rsp;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	top4_bone_weight_slots u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Private copy of the slot store, the sticky overflow flag and the vertex
	// count register. The bit type starts at zero, which matches reset.
	bit [WORD_W-1:0] bone_store   [VERTEX_DEPTH][SLOTS_PER_VERTEX];
	bit [WORD_W-1:0] weight_store [VERTEX_DEPTH][SLOTS_PER_VERTEX];
	bit              overflow_state;
	bit [CFG_W-1:0]  walk_count;

	cmd_item_t  queued_cmds [$];
	rsp_item_t  answers_due [$];

	// Handshake events seen at the last rising edge, read by the drivers at the
	// following falling edge.
	bit  cmd_fire;
	bit  rsp_fire;
	bit  cfg_fire;
	bit  calm_stretch;
	int  cmd_gap_left;
	int  ready_left;
	int  quiet_cycles;
	int  error_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one. During a calm
	// stretch neither side idles at all.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_stretch || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void wipe_store();
		int v;
		int s;
		for (v = 0; v < VERTEX_DEPTH; v++) begin
			for (s = 0; s < SLOTS_PER_VERTEX; s++) begin
				bone_store[v][s]   = '0;
				weight_store[v][s] = '0;
			end
		end
		overflow_state = 1'b0;
	endfunction

	// An add takes the first slot whose weight is zero. With every slot taken it
	// raises the overflow flag and replaces the first smallest slot, but only
	// when the new weight is strictly larger.
	function automatic outcome_t place_weight(int unsigned v, bit [WORD_W-1:0] bone,
			bit [WORD_W-1:0] w);
		int unsigned     s;
		int unsigned     low_s;
		bit [WORD_W-1:0] low_w;
		if (v >= VERTEX_DEPTH)
			return OUT_DISCARDED;
		for (s = 0; s < SLOTS_PER_VERTEX; s++) begin
			if (weight_store[v][s] == '0) begin
				bone_store[v][s]   = bone;
				weight_store[v][s] = w;
				return OUT_FREE;
			end
		end
		overflow_state = 1'b1;
		low_s = 0;
		low_w = weight_store[v][0];
		for (s = 1; s < SLOTS_PER_VERTEX; s++) begin
			if (weight_store[v][s] < low_w) begin
				low_s = s;
				low_w = weight_store[v][s];
			end
		end
		if (low_w < w) begin
			bone_store[v][low_s]   = bone;
			weight_store[v][low_s] = w;
			return OUT_REPLACED;
		end
		return OUT_DISCARDED;
	endfunction

	// Rescales each walked vertex so that its weights sum to one, rounding to
	// nearest and saturating at 0xFFFF. A vertex whose total is zero is skipped.
	function automatic void rescale_walked();
		int unsigned lim;
		int unsigned v;
		int unsigned s;
		bit [63:0]   total;
		bit [63:0]   q;
		if (!overflow_state)
			return;
		lim = (walk_count < VERTEX_DEPTH) ? walk_count : VERTEX_DEPTH;
		for (v = 0; v < lim; v++) begin
			total = '0;
			for (s = 0; s < SLOTS_PER_VERTEX; s++)
				total += weight_store[v][s];
			if (total != 0) begin
				for (s = 0; s < SLOTS_PER_VERTEX; s++) begin
					q = (({48'd0, weight_store[v][s]} << FRAC_W) + total / 2) / total;
					weight_store[v][s] = (q > 64'd65535) ? 16'hFFFF : q[WORD_W-1:0];
				end
			end
		end
	endfunction

	// Applies one command to the private store and returns the beat it must
	// produce. Adds and reads show the vertex after the command; normalize and
	// clear show zero slots.
	function automatic rsp_item_t predict_answer(cmd_item_t c);
		rsp_item_t   a;
		int unsigned v;
		a = '0;
		v = c.vertex_index;
		case (c.kind)
			KIND_ADD:  a.outcome = place_weight(v, c.bone_index, c.weight);
			KIND_READ: a.outcome = OUT_DONE;
			KIND_NORM: begin
				rescale_walked();
				a.outcome = OUT_DONE;
			end
			default: begin
				wipe_store();
				a.outcome = OUT_DONE;
			end
		endcase
		if ((c.kind == KIND_ADD || c.kind == KIND_READ) && v < VERTEX_DEPTH) begin
			a.bone_slot_a   = bone_store[v][0];
			a.bone_slot_b   = bone_store[v][1];
			a.bone_slot_c   = bone_store[v][2];
			a.bone_slot_d   = bone_store[v][3];
			a.weight_slot_a = weight_store[v][0];
			a.weight_slot_b = weight_store[v][1];
			a.weight_slot_c = weight_store[v][2];
			a.weight_slot_d = weight_store[v][3];
		end
		a.overflow_seen = overflow_state;
		return a;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	function automatic void queue_cmd(kind_t k, int unsigned v, int unsigned bone,
			int unsigned w);
		cmd_item_t c;
		c.kind         = k;
		c.vertex_index = v[VIDX_W-1:0];
		c.bone_index   = bone[WORD_W-1:0];
		c.weight       = w[WORD_W-1:0];
		queued_cmds.insert(queued_cmds.size(), c);
	endfunction

	// Random commands lean on a small pool of hot vertices so that slots fill
	// up, overflow and get replaced and rescaled; the rest spread over the whole
	// store, with the last vertex picked on purpose now and then.
	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		int        r;
		r = $urandom_range(0, 99);
		if (r < 68)
			c.kind = KIND_ADD;
		else if (r < 88)
			c.kind = KIND_READ;
		else if (r < 98)
			c.kind = KIND_NORM;
		else
			c.kind = KIND_CLEAR;
		r = $urandom_range(0, 99);
		if (r < 70)
			c.vertex_index = VIDX_W'($urandom_range(0, 7));
		else if (r < 85)
			c.vertex_index = VIDX_W'($urandom_range(0, 63));
		else if (r < 95)
			c.vertex_index = VIDX_W'($urandom_range(0, VERTEX_DEPTH - 1));
		else
			c.vertex_index = VIDX_W'(VERTEX_DEPTH - 1);
		c.bone_index = WORD_W'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 8)
			c.weight = '0;
		else if (r < 16)
			c.weight = 16'hFFFF;
		else if (r < 46)
			c.weight = WORD_W'($urandom_range(1, 255));
		else
			c.weight = WORD_W'($urandom_range(0, 65535));
		return c;
	endfunction

	// Register write: a setup cycle, then an access cycle held until pready.
	// The bits above the register width carry random junk that must be ignored.
	task automatic write_vertex_count(int unsigned value);
		logic [PDATA_W-1:0] bus_word;
		bus_word = $urandom();
		bus_word[CFG_W-1:0] = value[CFG_W-1:0];
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_VERTEX_COUNT;
		pwdata  <= bus_word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Idle means nothing left to send, no beat on the command channel and no
	// response still owed. Checked at the rising edge, where the valid driven
	// at the falling edge is settled.
	task automatic wait_idle();
		do @(posedge clk);
		while (queued_cmds.size() != 0 || cmd_valid || answers_due.size() != 0);
	endtask

	// Command driver: a beat stays up until it is taken, then an optional gap
	// precedes the next one.
	always @(negedge clk) begin
		if (!cmd_valid || cmd_fire) begin
			if (cmd_gap_left > 0) begin
				cmd_gap_left--;
				cmd_valid <= 1'b0;
			end else if (queued_cmds.size() != 0) begin
				cmd          <= queued_cmds.pop_front();
				cmd_valid    <= 1'b1;
				cmd_gap_left = pick_gap();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Response back-pressure: ready runs high for a while, then may drop for a
	// stall of random length.
	always @(negedge clk) begin
		if (ready_left > 0) begin
			ready_left--;
		end else if (rsp_ready) begin
			ready_left = pick_gap();
			if (ready_left > 0) begin
				rsp_ready  <= 1'b0;
				ready_left--;
			end else begin
				ready_left = $urandom_range(0, 6);
			end
		end else begin
			rsp_ready  <= 1'b1;
			ready_left = $urandom_range(0, 6);
		end
	end

	// Monitor: tracks register writes, predicts each accepted command, checks
	// each response beat against the oldest prediction, and runs the watchdog.
	always @(posedge clk) begin
		rsp_item_t want;
		cmd_fire = cmd_valid && cmd_ready;
		rsp_fire = rsp_valid && rsp_ready;
		cfg_fire = psel && penable && pwrite && pready;
		if (cfg_fire && paddr == ADDR_VERTEX_COUNT)
			walk_count = pwdata[CFG_W-1:0];
		if (cmd_fire)
			answers_due.insert(answers_due.size(), predict_answer(cmd));
		if (rsp_fire) begin
			if (answers_due.size() == 0) begin
				report_mismatch("response beat with no command pending", rsp.outcome, 0);
			end else begin
				want = answers_due.pop_front();
				if (rsp.outcome !== want.outcome)
					report_mismatch("outcome", rsp.outcome, want.outcome);
				if (rsp.bone_slot_a !== want.bone_slot_a)
					report_mismatch("bone_slot_a", rsp.bone_slot_a, want.bone_slot_a);
				if (rsp.bone_slot_b !== want.bone_slot_b)
					report_mismatch("bone_slot_b", rsp.bone_slot_b, want.bone_slot_b);
				if (rsp.bone_slot_c !== want.bone_slot_c)
					report_mismatch("bone_slot_c", rsp.bone_slot_c, want.bone_slot_c);
				if (rsp.bone_slot_d !== want.bone_slot_d)
					report_mismatch("bone_slot_d", rsp.bone_slot_d, want.bone_slot_d);
				if (rsp.weight_slot_a !== want.weight_slot_a)
					report_mismatch("weight_slot_a", rsp.weight_slot_a, want.weight_slot_a);
				if (rsp.weight_slot_b !== want.weight_slot_b)
					report_mismatch("weight_slot_b", rsp.weight_slot_b, want.weight_slot_b);
				if (rsp.weight_slot_c !== want.weight_slot_c)
					report_mismatch("weight_slot_c", rsp.weight_slot_c, want.weight_slot_c);
				if (rsp.weight_slot_d !== want.weight_slot_d)
					report_mismatch("weight_slot_d", rsp.weight_slot_d, want.weight_slot_d);
				if (rsp.overflow_seen !== want.overflow_seen)
					report_mismatch("overflow_seen", rsp.overflow_seen, want.overflow_seen);
			end
		end
		// Calm stretches come and go so that some runs of beats see no idling.
		if ($urandom_range(0, 249) == 0)
			calm_stretch = !calm_stretch;
		if (cmd_fire || rsp_fire || cfg_fire)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned walk_plan [PHASES];
		int          phase;
		int          n;
		walk_plan = '{1, 4096, 16, 0, 8191, 0, 2, 0};
		walk_plan[5] = $urandom_range(3, 200);
		walk_plan[7] = $urandom_range(1, 4096);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register port works during the clearing pass after reset, so the
		// first write goes in right away.
		write_vertex_count(0);

		// Empty vertices at both ends of the store.
		queue_cmd(KIND_READ, 0, 0, 0);
		queue_cmd(KIND_READ, VERTEX_DEPTH - 1, 0, 0);
		// Fill one vertex: the largest bone and weight first, then a zero
		// weight, which takes a slot but leaves it free for the next add.
		queue_cmd(KIND_ADD, 5, 16'hFFFF, 16'hFFFF);
		queue_cmd(KIND_ADD, 5, 16'h0000, 16'h0000);
		queue_cmd(KIND_ADD, 5, 16'h1234, 16'h0001);
		queue_cmd(KIND_ADD, 5, 16'hAAAA, 16'h8000);
		queue_cmd(KIND_ADD, 5, 16'h5555, 16'h0001);
		// Vertex full: a zero weight is dropped and raises the overflow flag, a
		// weight equal to the smallest is dropped, a larger one replaces the
		// lower-numbered of the two equal smallest slots.
		queue_cmd(KIND_ADD, 5, 16'h0BAD, 16'h0000);
		queue_cmd(KIND_ADD, 5, 16'h0C0C, 16'h0001);
		queue_cmd(KIND_ADD, 5, 16'h0F0F, 16'h0002);
		// Normalize over no vertices changes nothing.
		queue_cmd(KIND_NORM, 0, 0, 0);
		queue_cmd(KIND_READ, 5, 0, 0);
		// A lone full-scale weight rounds to exactly one and must saturate; a vertex
		// with a bone but zero weight has a zero total and is left alone.
		queue_cmd(KIND_ADD, 2, 16'h0007, 16'hFFFF);
		queue_cmd(KIND_ADD, 3, 16'h0033, 16'h0000);
		wait_idle();

		write_vertex_count(8);
		queue_cmd(KIND_NORM, 0, 0, 0);
		queue_cmd(KIND_READ, 5, 0, 0);
		queue_cmd(KIND_READ, 2, 0, 0);
		queue_cmd(KIND_READ, 3, 0, 0);
		// Clear drops the flag, after which normalize has nothing to do.
		queue_cmd(KIND_CLEAR, 0, 0, 0);
		queue_cmd(KIND_READ, 5, 0, 0);
		queue_cmd(KIND_ADD, 5, 16'h00FF, 16'h0100);
		queue_cmd(KIND_NORM, 0, 0, 0);
		queue_cmd(KIND_READ, 5, 0, 0);
		queue_cmd(KIND_ADD, VERTEX_DEPTH - 1, 16'hFFFF, 16'h4000);
		queue_cmd(KIND_READ, VERTEX_DEPTH - 1, 0, 0);
		wait_idle();

		// Random phases, each under its own vertex count: zero, small ones, the
		// full store and a value past the store that must be limited to it.
		for (phase = 0; phase < PHASES; phase++) begin
			write_vertex_count(walk_plan[phase]);
			for (n = 0; n < PHASE_ITEMS; n++)
				queued_cmds.insert(queued_cmds.size(), random_cmd());
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
